// ===== hdl/delimited_frame_classifier_macros.svh =====
// Assertion macros used by the frame classifier core (dfc_frame_core).
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef DELIMITED_FRAME_CLASSIFIER_MACROS_SVH
`define DELIMITED_FRAME_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dfc_pkg.sv =====
// Types and constants of the delimited frame classifier.
// No dependencies; used by every module of the block.
package dfc_pkg;

    localparam int LEN_W   = 6;
    localparam int CNT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_START    = 3'd0;
    localparam logic [IDX_W-1:0] REG_END      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPECIAL  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RESET    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CONNECT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CONTINUE = 3'd5;
    localparam logic [IDX_W-1:0] REG_TRANSEND = 3'd6;
    localparam logic [IDX_W-1:0] REG_CLEAR    = 3'd7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONNECT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTINUE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRANSEND = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] start_symbol;
        logic [BYTE_W-1:0] end_symbol;
        logic [BYTE_W-1:0] special_symbol;
        logic [BYTE_W-1:0] reset_count;
        logic [BYTE_W-1:0] connect_count;
        logic [BYTE_W-1:0] continue_count;
        logic [BYTE_W-1:0] transend_count;
        logic [BYTE_W-1:0] clear_count;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic             frame_valid;
        logic             all_special;
        logic [CNT_W-1:0] middle_special_count;
        logic [CMD_W-1:0] command_code;
    } result_t;

endpackage

// ===== hdl/dfc_apb_regs.sv =====
// APB register file of the frame classifier: symbols and repeat counts.
// Depends on dfc_pkg.
module dfc_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dfc_pkg::ADDR_W-1:0] paddr,
    input  logic [dfc_pkg::DATA_W-1:0] pwdata,
    output logic [dfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dfc_pkg::cfg_t              cfg
);

    dfc_pkg::cfg_t              cfg_reg;
    dfc_pkg::cfg_t              cfg_next;
    logic [dfc_pkg::IDX_W-1:0]  idx;
    logic [dfc_pkg::BYTE_W-1:0] wbyte;
    logic [dfc_pkg::BYTE_W-1:0] rbyte;
    logic                       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[dfc_pkg::ADDR_W-1:2];
    assign wbyte  = pwdata[dfc_pkg::BYTE_W-1:0];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                dfc_pkg::REG_START:    cfg_next.start_symbol   = wbyte;
                dfc_pkg::REG_END:      cfg_next.end_symbol     = wbyte;
                dfc_pkg::REG_SPECIAL:  cfg_next.special_symbol = wbyte;
                dfc_pkg::REG_RESET:    cfg_next.reset_count    = wbyte;
                dfc_pkg::REG_CONNECT:  cfg_next.connect_count  = wbyte;
                dfc_pkg::REG_CONTINUE: cfg_next.continue_count = wbyte;
                dfc_pkg::REG_TRANSEND: cfg_next.transend_count = wbyte;
                dfc_pkg::REG_CLEAR:    cfg_next.clear_count    = wbyte;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            dfc_pkg::REG_START:    rbyte = cfg_reg.start_symbol;
            dfc_pkg::REG_END:      rbyte = cfg_reg.end_symbol;
            dfc_pkg::REG_SPECIAL:  rbyte = cfg_reg.special_symbol;
            dfc_pkg::REG_RESET:    rbyte = cfg_reg.reset_count;
            dfc_pkg::REG_CONNECT:  rbyte = cfg_reg.connect_count;
            dfc_pkg::REG_CONTINUE: rbyte = cfg_reg.continue_count;
            dfc_pkg::REG_TRANSEND: rbyte = cfg_reg.transend_count;
            dfc_pkg::REG_CLEAR:    rbyte = cfg_reg.clear_count;
            default:               rbyte = '0;
        endcase
    end

    assign prdata = {{(dfc_pkg::DATA_W-dfc_pkg::BYTE_W){1'b0}}, rbyte};
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_symbol   <= 8'd2;
            cfg_reg.end_symbol     <= 8'd3;
            cfg_reg.special_symbol <= 8'd42;
            cfg_reg.reset_count    <= 8'd8;
            cfg_reg.connect_count  <= 8'd3;
            cfg_reg.continue_count <= 8'd1;
            cfg_reg.transend_count <= 8'd2;
            cfg_reg.clear_count    <= 8'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/dfc_frame_core.sv =====
// Input beat register, running frame state and per-byte classification.
// Depends on dfc_pkg and delimited_frame_classifier_macros.svh.
`include "delimited_frame_classifier_macros.svh"

module dfc_frame_core #(
    parameter int MAX_FRAME = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dfc_pkg::cfg_t              cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dfc_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       out_free,
    output logic                       res_load,
    output dfc_pkg::result_t           res
);

    localparam logic [dfc_pkg::LEN_W-1:0] MAX_LEN = dfc_pkg::LEN_W'(MAX_FRAME);
    localparam logic [dfc_pkg::LEN_W-1:0] TOP_LEN = dfc_pkg::LEN_W'(MAX_FRAME + 1);

    logic                       in_valid_reg;
    logic [dfc_pkg::BYTE_W-1:0] byte_reg;

    logic [dfc_pkg::LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic                       first_start_reg, first_start_next;
    logic                       all_special_reg, all_special_next;
    logic [dfc_pkg::LEN_W-1:0]  run_count_reg, run_count_next;

    logic                       restart, is_end, is_start, move;
    logic [dfc_pkg::LEN_W-1:0]  pos, len, run_cur;
    logic                       all_cur, first_cur;
    logic [dfc_pkg::BYTE_W-1:0] run_ext;
    logic [dfc_pkg::CMD_W-1:0]  cmd;

    assign is_start = (byte_reg == cfg.start_symbol);
    assign is_end   = (byte_reg == cfg.end_symbol);
    assign restart  = is_start || (frame_len_reg > MAX_LEN);
    assign pos      = restart ? '0 : frame_len_reg;
    assign all_cur  = restart ? 1'b1 : all_special_reg;
    assign run_cur  = restart ? '0 : run_count_reg;
    assign first_cur = (pos == '0) ? is_start : first_start_reg;
    assign len      = pos + dfc_pkg::LEN_W'(1);
    assign run_ext  = {{(dfc_pkg::BYTE_W-dfc_pkg::LEN_W){1'b0}}, run_cur};

    // first matching count wins
    always_comb begin
        if (!all_cur)                         cmd = dfc_pkg::CMD_NONE;
        else if (run_ext == cfg.reset_count)    cmd = dfc_pkg::CMD_RESET;
        else if (run_ext == cfg.connect_count)  cmd = dfc_pkg::CMD_CONNECT;
        else if (run_ext == cfg.continue_count) cmd = dfc_pkg::CMD_CONTINUE;
        else if (run_ext == cfg.transend_count) cmd = dfc_pkg::CMD_TRANSEND;
        else if (run_ext == cfg.clear_count)    cmd = dfc_pkg::CMD_CLEAR;
        else                                    cmd = dfc_pkg::CMD_NONE;
    end

    always_comb begin
        res.frame_length         = len;
        res.frame_valid          = (len > dfc_pkg::LEN_W'(2)) && first_cur;
        res.all_special          = all_cur;
        res.middle_special_count = all_cur ? run_cur[dfc_pkg::CNT_W-1:0] : '0;
        res.command_code         = cmd;
    end

    // a beat without a result never waits for the output slot
    assign move     = in_valid_reg && (!is_end || out_free);
    assign res_load = move && is_end;
    assign s_ready  = !in_valid_reg || move;

    always_comb begin
        frame_len_next   = frame_len_reg;
        first_start_next = first_start_reg;
        all_special_next = all_special_reg;
        run_count_next   = run_count_reg;
        if (move) begin
            frame_len_next   = len;
            first_start_next = first_cur;
            all_special_next = all_cur;
            run_count_next   = run_cur;
            if (pos != '0) begin
                if (all_cur && (byte_reg == cfg.special_symbol)) begin
                    run_count_next = run_cur + dfc_pkg::LEN_W'(1);
                end else begin
                    all_special_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            frame_len_reg   <= '0;
            first_start_reg <= 1'b0;
            all_special_reg <= 1'b1;
            run_count_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            frame_len_reg   <= frame_len_next;
            first_start_reg <= first_start_next;
            all_special_reg <= all_special_next;
            run_count_reg   <= run_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_rx_byte;
        end
    end

    `DFC_ASSERT_NOW(a_len_bound, 1'b1, frame_len_reg <= TOP_LEN, "frame length past limit")
    `DFC_ASSERT_NOW(a_run_bound, 1'b1, run_count_reg <= frame_len_reg, "run count above length")
    `DFC_ASSERT_NOW(a_valid_len, res_load && res.frame_valid,
        res.frame_length > dfc_pkg::LEN_W'(2), "valid frame too short")
    `DFC_ASSERT_NEXT(a_hold_beat, in_valid_reg && !move,
        in_valid_reg && $stable(byte_reg), "stalled input beat lost")

endmodule

// ===== hdl/dfc_result_reg.sv =====
// Output register of the result channel.
// Depends on dfc_pkg.
module dfc_result_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       res_load,
    input  dfc_pkg::result_t           res,
    output logic                       out_free,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [dfc_pkg::LEN_W-1:0]  m_frame_length,
    output logic                       m_frame_valid,
    output logic                       m_all_special,
    output logic [dfc_pkg::CNT_W-1:0]  m_middle_special_count,
    output logic [dfc_pkg::CMD_W-1:0]  m_command_code
);

    logic             out_valid_reg;
    dfc_pkg::result_t out_reg;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_frame_length         = out_reg.frame_length;
    assign m_frame_valid          = out_reg.frame_valid;
    assign m_all_special          = out_reg.all_special;
    assign m_middle_special_count = out_reg.middle_special_count;
    assign m_command_code         = out_reg.command_code;

endmodule

// ===== hdl/delimited_frame_classifier.sv =====
// Top level of the delimited frame classifier.
// Depends on dfc_pkg, dfc_apb_regs, dfc_frame_core and dfc_result_reg.
//
// Usage:
//   s_ channel: one received byte per beat (s_rx_byte), valid/ready.
//   m_ channel: one result beat for every byte equal to the end symbol:
//     frame length, valid flag, all-special flag, middle count, command.
//     Bytes that are not an end symbol produce no beat.
//   APB port: eight 8-bit registers at byte address 4*i (start, end,
//     special symbols, then reset/connect/continue/transend/clear counts).
//     Write only while no bytes are in flight.
// Timing:
//   An accepted byte lands in the input beat register and is classified
//   against the running frame state; an end byte's result then moves to
//   the output register, and m_valid stays high until it is taken.
//   Throughput is one byte per cycle while no end byte stalls (below).
// Reset: aresetn low (synchronous) loads the register defaults, empties
//   both beat registers and clears the frame state.
// Stall: while m_ready is low the result is held; bytes that produce no
//   result keep flowing, and an end byte waits in the input register,
//   which pulls s_ready low.
module delimited_frame_classifier #(
    parameter int MAX_FRAME = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dfc_pkg::ADDR_W-1:0] paddr,
    input  logic [dfc_pkg::DATA_W-1:0] pwdata,
    output logic [dfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dfc_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [dfc_pkg::LEN_W-1:0]  m_frame_length,
    output logic                       m_frame_valid,
    output logic                       m_all_special,
    output logic [dfc_pkg::CNT_W-1:0]  m_middle_special_count,
    output logic [dfc_pkg::CMD_W-1:0]  m_command_code
);

    dfc_pkg::cfg_t    cfg;
    dfc_pkg::result_t res;
    logic             res_load;
    logic             out_free;

    // configuration registers
    dfc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input beat register plus running frame state
    dfc_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res)
    );

    // result beat register
    dfc_result_reg u_out (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .res_load               (res_load),
        .res                    (res),
        .out_free               (out_free),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_frame_length         (m_frame_length),
        .m_frame_valid          (m_frame_valid),
        .m_all_special          (m_all_special),
        .m_middle_special_count (m_middle_special_count),
        .m_command_code         (m_command_code)
    );

endmodule
